### sv/mf3_pkg.sv
// Shared types, constants and compare helpers for the 3x3 median filter.
// Depends on nothing; every other file refers to it by scoped names.
package mf3_pkg;

  localparam int PixW    = 8;
  localparam int PosW    = 12;
  localparam int CfgW    = 13;
  localparam int QDepth  = 4;
  localparam int QPtrW   = 2;
  localparam int QCntW   = 3;
  localparam int MinDim  = 3;
  localparam int MaxRows = 4096;

  // register indexes on the configuration port
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // one column of the neighborhood plus the result position
  typedef struct packed {
    logic [PixW-1:0] top;
    logic [PixW-1:0] mid;
    logic [PixW-1:0] cur;
    logic            emit;
    logic            zero;
    logic [PosW-1:0] out_row;
    logic [PosW-1:0] out_col;
    logic            last;
  } column_t;

  function automatic logic [PixW-1:0] max3(input logic [PixW-1:0] a,
                                           input logic [PixW-1:0] b,
                                           input logic [PixW-1:0] c);
    logic [PixW-1:0] m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  function automatic logic [PixW-1:0] min3(input logic [PixW-1:0] a,
                                           input logic [PixW-1:0] b,
                                           input logic [PixW-1:0] c);
    logic [PixW-1:0] m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic logic [PixW-1:0] med3(input logic [PixW-1:0] a,
                                           input logic [PixW-1:0] b,
                                           input logic [PixW-1:0] c);
    logic [PixW-1:0] lo;
    logic [PixW-1:0] hi;
    logic [PixW-1:0] m;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    m  = (hi < c) ? hi : c;
    return (lo > m) ? lo : m;
  endfunction

endpackage

### sv/mf3_queue.sv
// Short FIFO of columns between the front and the back of the median filter.
// Depends on mf3_pkg for the column type and depth.
module mf3_queue (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  mf3_pkg::column_t         push_data,
  input  logic                     pop,
  output mf3_pkg::column_t         pop_data,
  output logic                     valid,
  output logic [mf3_pkg::QCntW-1:0] count
);

  mf3_pkg::column_t                entries [mf3_pkg::QDepth];
  logic [mf3_pkg::QPtrW-1:0]       wr_ptr;
  logic [mf3_pkg::QPtrW-1:0]       rd_ptr;

  assign valid    = (count != '0);
  assign pop_data = entries[rd_ptr];

  // store the new column
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (!push && pop) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |-> (count < mf3_pkg::QCntW'(mf3_pkg::QDepth)))
    else $error("column queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> (count != '0))
    else $error("column queue underflow");
`endif

endmodule

### sv/mf3_front.sv
// Front of the median filter: frame position, line buffer memory, column build.
// Depends on mf3_pkg; feeds mf3_queue.
module mf3_front #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [mf3_pkg::CfgW-1:0]   frame_width,
  input  logic [mf3_pkg::CfgW-1:0]   frame_height,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [mf3_pkg::PixW-1:0]   pixel,
  input  logic [mf3_pkg::QCntW-1:0]  q_count,
  output logic                       push,
  output mf3_pkg::column_t           push_data
);

  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int AW = $clog2(MAX_WIDTH);
  localparam int RW = mf3_pkg::PosW;

  logic [CW-1:0]               w_eff;
  logic [mf3_pkg::CfgW-1:0]    h_eff;
  logic [CW-1:0]               col_count;
  logic [RW-1:0]               row_count;
  logic [CW-1:0]               col_count_next;
  logic [RW-1:0]               row_count_next;
  logic [CW-1:0]               c_cur;
  logic [RW:0]                 r_tmp;
  logic [RW-1:0]               r_cur;
  logic [CW:0]                 c_inc;
  logic [RW:0]                 r_inc;
  logic                        accept;
  logic [mf3_pkg::QCntW:0]     inflight;

  logic [2*mf3_pkg::PixW-1:0]  lines [MAX_WIDTH];
  logic [2*mf3_pkg::PixW-1:0]  rdata;

  logic                        f1_valid;
  logic [mf3_pkg::PixW-1:0]    f1_px;
  logic [RW-1:0]               f1_r;
  logic [CW-1:0]               f1_c;
  logic [31:0]                 ocol;

  // clamp the geometry into its legal range
  always_comb begin
    if (frame_width < mf3_pkg::CfgW'(mf3_pkg::MinDim)) begin
      w_eff = CW'(mf3_pkg::MinDim);
    end else if (32'(frame_width) > MAX_WIDTH) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = CW'(frame_width);
    end
    if (frame_height < mf3_pkg::CfgW'(mf3_pkg::MinDim)) begin
      h_eff = mf3_pkg::CfgW'(mf3_pkg::MinDim);
    end else if (32'(frame_height) > mf3_pkg::MaxRows) begin
      h_eff = mf3_pkg::CfgW'(mf3_pkg::MaxRows);
    end else begin
      h_eff = frame_height;
    end
  end

  // position of this pixel, then of the next one
  always_comb begin
    if (col_count >= w_eff) begin
      c_cur = '0;
      r_tmp = {1'b0, row_count} + 1'b1;
    end else begin
      c_cur = col_count;
      r_tmp = {1'b0, row_count};
    end
    r_cur = (r_tmp >= h_eff) ? '0 : r_tmp[RW-1:0];
    c_inc = {1'b0, c_cur} + 1'b1;
    r_inc = {1'b0, r_cur} + 1'b1;
    if (c_inc >= {1'b0, w_eff}) begin
      col_count_next = '0;
      row_count_next = (r_inc >= h_eff) ? '0 : r_inc[RW-1:0];
    end else begin
      col_count_next = c_inc[CW-1:0];
      row_count_next = r_cur;
    end
  end

  // take a pixel only while the queue has a slot for it
  assign inflight = {1'b0, q_count} + (mf3_pkg::QCntW + 1)'(f1_valid);
  assign s_tready = inflight < (mf3_pkg::QCntW + 1)'(mf3_pkg::QDepth);
  assign accept   = s_tvalid && s_tready;

  // line buffers: one word per column, {two rows above, one row above}
  always_ff @(posedge clk) begin
    if (f1_valid) begin
      lines[f1_c[AW-1:0]] <= {rdata[mf3_pkg::PixW-1:0], f1_px};
    end
    if (accept) begin
      rdata <= lines[c_cur[AW-1:0]];
    end
  end

  // hold the pixel while its column is read
  always_ff @(posedge clk) begin
    if (accept) begin
      f1_px <= pixel;
      f1_r  <= r_cur;
      f1_c  <= c_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid  <= 1'b0;
      col_count <= '0;
      row_count <= '0;
    end else begin
      f1_valid <= accept;
      if (accept) begin
        col_count <= col_count_next;
        row_count <= row_count_next;
      end
    end
  end

  // classify the column and push it
  assign ocol = 32'(f1_c) - 32'd1;
  assign push = f1_valid;

  always_comb begin
    push_data.top     = rdata[2*mf3_pkg::PixW-1:mf3_pkg::PixW];
    push_data.mid     = rdata[mf3_pkg::PixW-1:0];
    push_data.cur     = f1_px;
    push_data.emit    = (f1_r != '0) && (f1_c != '0);
    push_data.zero    = !((f1_r >= RW'(2)) && (32'(f1_c) >= 32'd2));
    push_data.out_row = f1_r - 1'b1;
    push_data.out_col = ocol[mf3_pkg::PosW-1:0];
    push_data.last    = (32'(f1_r) == 32'(h_eff) - 32'd1) &&
                        (32'(f1_c) == 32'(w_eff) - 32'd1);
  end

endmodule

### sv/mf3_back.sv
// Back of the median filter: sorted-column window, median reduction, output word.
// Depends on mf3_pkg; drains mf3_queue.
module mf3_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_valid,
  input  mf3_pkg::column_t           q_data,
  output logic                       q_pop,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [31:0]                m_tdata,   // filtered[7:0], out_row[19:8], out_col[31:20]
  output logic                       m_tlast    // frame_last
);

  localparam int PW = mf3_pkg::PixW;
  localparam int RW = mf3_pkg::PosW;

  logic [PW-1:0] win_lo  [3];
  logic [PW-1:0] win_mid [3];
  logic [PW-1:0] win_hi  [3];

  logic          s1_v;
  logic          s1_zero;
  logic [RW-1:0] s1_row;
  logic [RW-1:0] s1_col;
  logic          s1_last;

  logic          s2_v;
  logic          s2_zero;
  logic [RW-1:0] s2_row;
  logic [RW-1:0] s2_col;
  logic          s2_last;
  logic [PW-1:0] s2_lo_max;
  logic [PW-1:0] s2_mid_med;
  logic [PW-1:0] s2_hi_min;

  logic          out_en;
  logic          s2_en;
  logic          s1_en;
  logic [PW-1:0] median;

  // stall chain from the output back to the queue
  assign out_en = !m_tvalid || m_tready;
  assign s2_en  = !s2_v || out_en;
  assign s1_en  = !s1_v || s2_en;
  assign q_pop  = q_valid && s1_en;

  // sort the incoming column and shift it into the window
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 3; k++) begin
        win_lo[k]  <= '0;
        win_mid[k] <= '0;
        win_hi[k]  <= '0;
      end
    end else if (q_pop) begin
      win_lo[0]  <= win_lo[1];
      win_lo[1]  <= win_lo[2];
      win_lo[2]  <= mf3_pkg::min3(q_data.top, q_data.mid, q_data.cur);
      win_mid[0] <= win_mid[1];
      win_mid[1] <= win_mid[2];
      win_mid[2] <= mf3_pkg::med3(q_data.top, q_data.mid, q_data.cur);
      win_hi[0]  <= win_hi[1];
      win_hi[1]  <= win_hi[2];
      win_hi[2]  <= mf3_pkg::max3(q_data.top, q_data.mid, q_data.cur);
    end
  end

  // stage 1: position of the result whose window was just formed
  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_zero <= q_data.zero;
      s1_row  <= q_data.out_row;
      s1_col  <= q_data.out_col;
      s1_last <= q_data.last;
    end
  end

  // stage 2: reduce rows of the sorted window
  always_ff @(posedge clk) begin
    if (s2_en) begin
      s2_zero    <= s1_zero;
      s2_row     <= s1_row;
      s2_col     <= s1_col;
      s2_last    <= s1_last;
      s2_lo_max  <= mf3_pkg::max3(win_lo[0], win_lo[1], win_lo[2]);
      s2_mid_med <= mf3_pkg::med3(win_mid[0], win_mid[1], win_mid[2]);
      s2_hi_min  <= mf3_pkg::min3(win_hi[0], win_hi[1], win_hi[2]);
    end
  end

  assign median = mf3_pkg::med3(s2_lo_max, s2_mid_med, s2_hi_min);

  // output word
  always_ff @(posedge clk) begin
    if (out_en) begin
      m_tdata <= {s2_col, s2_row, (s2_zero ? PW'(0) : median)};
      m_tlast <= s2_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v     <= 1'b0;
      s2_v     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_v <= q_pop && q_data.emit;
      end
      if (s2_en) begin
        s2_v <= s1_v;
      end
      if (out_en) begin
        m_tvalid <= s2_v;
      end
    end
  end

`ifndef ASSERT_OFF
  a_pop_needs_room: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (!s1_v || s2_en))
    else $error("window shifted under a held result");

  a_s2_holds: assert property (@(posedge clk) disable iff (rst)
    (s2_v && !s2_en) |=> s2_v)
    else $error("reduction stage dropped a result");

  a_border_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && ((m_tdata[19:8] == '0) || (m_tdata[31:20] == '0))) |->
      (m_tdata[7:0] == '0))
    else $error("nonzero value on top row or left column");
`endif

endmodule

### sv/median_filter_3x3.sv
// Top level of the 3x3 median filter: configuration registers and the front,
// queue and back parts. Depends on mf3_pkg, mf3_front, mf3_queue, mf3_back.
//
//  channel   dir   handshake              contents
//  s_*       in    s_tvalid / s_tready    pixel[7:0]
//  m_*       out   m_tvalid / m_tready    filtered, out_row, out_col; tlast = frame_last
//  apb       in    psel/penable/pready    frame_width @0x0, frame_height @0x4
//
//  One pixel per clock while the column queue has room; the line buffer takes one
//  read and one write each cycle.
//  Reset (rst, synchronous) clears position, valid flags and sets 640 x 480; line
//  buffers are not cleared, the window fills before any median uses it.
//  A four-entry column queue lets the front keep taking pixels while the output stalls.
module median_filter_3x3 #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // pixel[7:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // filtered[7:0], out_row[19:8], out_col[31:20]
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [mf3_pkg::CfgW-1:0]  frame_width;
  logic [mf3_pkg::CfgW-1:0]  frame_height;
  logic                      reg_wr;
  logic                      reg_idx;
  logic                      q_push;
  mf3_pkg::column_t          q_push_data;
  logic                      q_pop;
  mf3_pkg::column_t          q_pop_data;
  logic                      q_valid;
  logic [mf3_pkg::QCntW-1:0] q_count;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign reg_wr  = psel && penable && pwrite && pready;

  // write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= mf3_pkg::CfgW'(640);
      frame_height <= mf3_pkg::CfgW'(480);
    end else if (reg_wr) begin
      case (reg_idx)
        mf3_pkg::REG_WIDTH:  frame_width  <= pwdata[mf3_pkg::CfgW-1:0];
        mf3_pkg::REG_HEIGHT: frame_height <= pwdata[mf3_pkg::CfgW-1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (reg_idx)
      mf3_pkg::REG_WIDTH:  prdata = 32'(frame_width);
      mf3_pkg::REG_HEIGHT: prdata = 32'(frame_height);
      default:             prdata = '0;
    endcase
  end

  mf3_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .frame_width (frame_width),
    .frame_height(frame_height),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .pixel       (s_tdata),
    .q_count     (q_count),
    .push        (q_push),
    .push_data   (q_push_data)
  );

  mf3_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_data(q_push_data),
    .pop      (q_pop),
    .pop_data (q_pop_data),
    .valid    (q_valid),
    .count    (q_count)
  );

  mf3_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_data  (q_pop_data),
    .q_pop   (q_pop),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
  );

endmodule

### tb/tb_median_filter_3x3.sv
// Self-checking testbench for median_filter_3x3: streams grey frames through the
// pixel port, predicts every filtered word and compares it field by field.
// Depends on mf3_pkg and the median_filter_3x3 RTL.
module tb_median_filter_3x3;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PixW         = mf3_pkg::PixW;
  localparam int PosW         = mf3_pkg::PosW;
  localparam int CfgW         = mf3_pkg::CfgW;
  localparam int MinDim       = mf3_pkg::MinDim;
  localparam int MaxRows      = mf3_pkg::MaxRows;
  localparam int LineLen      = 4096;
  localparam int StallLimit   = 2000;
  localparam int TotalPixels  = 1300;
  localparam int WidePixels   = 100;
  localparam int SettleCycles = 12;
  localparam int MaxPrints    = 40;
  localparam int HoldCycles   = 200;

  typedef enum int {FILL_UNIFORM, FILL_BINARY, FILL_FLAT, FILL_SPECKLE} fill_t;

  typedef struct {
    logic [PixW-1:0] filtered;
    logic [PosW-1:0] row;
    logic [PosW-1:0] col;
    logic            last;
  } pixel_result_t;

  // Predicts the filtered stream and holds the words still owed by the block
  class median_scoreboard;
    logic [CfgW-1:0] width_reg;
    logic [CfgW-1:0] height_reg;
    logic [PixW-1:0] row_above [LineLen];
    logic [PixW-1:0] row_two_above [LineLen];
    logic [PixW-1:0] nbhd [9];
    int unsigned     col_pos;
    int unsigned     row_pos;
    pixel_result_t   expected_q [$];
    int              errors;

    function new();
      width_reg  = 13'd640;
      height_reg = 13'd480;
      foreach (row_above[i]) row_above[i] = '0;
      foreach (row_two_above[i]) row_two_above[i] = '0;
      foreach (nbhd[i]) nbhd[i] = '0;
      col_pos = 0;
      row_pos = 0;
      errors  = 0;
    endfunction

    function int unsigned eff_width();
      int unsigned w;
      w = width_reg;
      if (w < MinDim) w = MinDim;
      if (w > LineLen) w = LineLen;
      return w;
    endfunction

    function int unsigned eff_height();
      int unsigned h;
      h = height_reg;
      if (h < MinDim) h = MinDim;
      if (h > MaxRows) h = MaxRows;
      return h;
    endfunction

    function void set_reg(logic idx, logic [CfgW-1:0] value);
      if (idx == mf3_pkg::REG_WIDTH) width_reg = value;
      else height_reg = value;
    endfunction

    // pixels still needed to close the current frame, zero at a frame start
    function int unsigned frame_rest();
      int unsigned w, h, c, r;
      w = eff_width();
      h = eff_height();
      c = col_pos;
      r = row_pos;
      if (c >= w) begin
        c = 0;
        r++;
      end
      if (r >= h) r = 0;
      if (r == 0 && c == 0) return 0;
      return (h - r) * w - c;
    endfunction

    // the median is the value with at most four below it and at least five at or below
    function logic [PixW-1:0] median_of_nine();
      int lt, le;
      for (int i = 0; i < 9; i++) begin
        lt = 0;
        le = 0;
        for (int j = 0; j < 9; j++) begin
          if (nbhd[j] < nbhd[i]) lt++;
          if (nbhd[j] <= nbhd[i]) le++;
        end
        if (lt <= 4 && le > 4) return nbhd[i];
      end
      return '0;
    endfunction

    function void note_pixel(logic [PixW-1:0] px);
      int unsigned   w, h, r, c;
      logic [PixW-1:0] top, mid;
      pixel_result_t res;
      w = eff_width();
      h = eff_height();
      // a shrunk geometry may leave the position past the row or frame end
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos++;
      end
      if (row_pos >= h) row_pos = 0;
      r = row_pos;
      c = col_pos;
      // rotate the line buffers at this column
      top = row_two_above[c];
      mid = row_above[c];
      row_two_above[c] = mid;
      row_above[c] = px;
      // shift the window one column left and load the new column
      for (int k = 0; k < 3; k++) begin
        nbhd[3*k]   = nbhd[3*k+1];
        nbhd[3*k+1] = nbhd[3*k+2];
      end
      nbhd[2] = top;
      nbhd[5] = mid;
      nbhd[8] = px;
      // advance the raster position
      col_pos = c + 1;
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos = r + 1;
        if (row_pos >= h) row_pos = 0;
      end
      // one word per pixel once a full neighborhood center is behind us
      if (r >= 1 && c >= 1) begin
        res.filtered = (r >= 2 && c >= 2) ? median_of_nine() : '0;
        res.row      = PosW'(r - 1);
        res.col      = PosW'(c - 1);
        res.last     = (r == h - 1) && (c == w - 1);
        expected_q.push_back(res);
      end
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MaxPrints) $display("%0t ns: %s", $time, msg);
    endtask

    task check_word(logic [31:0] data, logic last);
      pixel_result_t exp_res;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected output word %h last %b", data, last));
        return;
      end
      exp_res = expected_q.pop_front();
      if (data[PixW-1:0] !== exp_res.filtered)
        report($sformatf("pixel (%0d,%0d): filtered %h, expected %h", exp_res.row,
                         exp_res.col, data[PixW-1:0], exp_res.filtered));
      if (data[PixW+PosW-1:PixW] !== exp_res.row)
        report($sformatf("out_row %0d, expected %0d", data[PixW+PosW-1:PixW],
                         exp_res.row));
      if (data[PixW+2*PosW-1:PixW+PosW] !== exp_res.col)
        report($sformatf("out_col %0d, expected %0d", data[PixW+2*PosW-1:PixW+PosW],
                         exp_res.col));
      if (last !== exp_res.last)
        report($sformatf("pixel (%0d,%0d): tlast %b, expected %b", exp_res.row,
                         exp_res.col, last, exp_res.last));
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // pixel[7:0]
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;   // filtered[7:0], out_row[19:8], out_col[31:20]
  logic        m_tlast;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  median_scoreboard sb;
  bit src_idle_on;
  bit sink_idle_on;
  int sink_hold;
  int quiet_cycles = 0;
  int unsigned pixels_sent = 0;

  // two tiny frames, both with out-of-range geometry: binary and tied values
  logic [7:0] corner_px [18] = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF,
                                 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                                 8'h01, 8'hFE, 8'h80, 8'h7F, 8'hFF, 8'h00};

  median_filter_3x3 uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == StallLimit) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // check every accepted output word
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_word(m_tdata, m_tlast);
  end

  function automatic int idle_len();
    if ($urandom_range(0, 6) == 0) return $urandom_range(8, 30);
    return $urandom_range(1, 3);
  endfunction

  // output side: hold off on request, otherwise stall at random
  initial begin
    int stall_left;
    stall_left = 0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        m_tready <= 1'b0;
      end else if (sink_hold > 0) begin
        m_tready <= 1'b0;
        sink_hold--;
      end else if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
        if (sink_idle_on && $urandom_range(0, 4) == 0) stall_left = idle_len();
      end
    end
  end

  function automatic logic [7:0] pick_pixel(fill_t fill);
    case (fill)
      FILL_UNIFORM: return 8'($urandom_range(0, 255));
      FILL_BINARY:  return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      FILL_FLAT:    return 8'($urandom_range(118, 121));
      default: begin
        if ($urandom_range(0, 4) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
        return 8'($urandom_range(96, 104));
      end
    endcase
  endfunction

  function automatic int unsigned pick_width();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 2);
      1: return $urandom_range(13, 40);
      default: return $urandom_range(3, 12);
    endcase
  endfunction

  function automatic int unsigned pick_height(int unsigned w);
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 2);
      1: return (w <= 12) ? $urandom_range(9, 16) : $urandom_range(3, 5);
      default: return $urandom_range(3, 8);
    endcase
  endfunction

  // offer one pixel word, optionally after a gap, and hold it until taken
  task automatic send_pixel(logic [7:0] px);
    int gap;
    gap = (src_idle_on && $urandom_range(0, 3) == 0) ? idle_len() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= px;
    do @(posedge clk); while (!s_tready);
    sb.note_pixel(px);
    pixels_sent++;
  endtask

  task automatic feed(int unsigned count, fill_t fill);
    repeat (count) send_pixel(pick_pixel(fill));
  endtask

  // drop valid, wait for every owed word, then let the pipeline settle
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // write one register, then read it back
  task automatic write_reg(logic idx, logic [31:0] value);
    logic [31:0] readback;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, value[CfgW-1:0]);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    readback = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (readback[CfgW-1:0] !== value[CfgW-1:0])
      sb.report($sformatf("register %0d reads %h, wrote %h", idx, readback, value));
  endtask

  task automatic set_geometry(int unsigned w, int unsigned h);
    write_reg(mf3_pkg::REG_WIDTH, w);
    write_reg(mf3_pkg::REG_HEIGHT, h);
  endtask

  // width register above the line length, largest height, then narrow mid-frame
  task automatic wide_phase();
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b1;
    set_geometry(8191, 3);
    feed(WidePixels, FILL_UNIFORM);
    drain_results();
    set_geometry(LineLen, 8191);
    feed(4, FILL_SPECKLE);
    drain_results();
    set_geometry(6, 4);
    feed(sb.frame_rest(), FILL_UNIFORM);
    drain_results();
  endtask

  initial begin
    int unsigned w, h, k, rest;
    bit          wide_done;
    fill_t       fill;
    sb = new();
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    sink_hold    = 0;
    wide_done    = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: widths and heights below the minimum act as three
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    set_geometry(1, 2);
    for (int i = 0; i < 9; i++) send_pixel(corner_px[i]);
    drain_results();
    set_geometry(2, 0);
    for (int i = 9; i < 18; i++) send_pixel(corner_px[i]);
    drain_results();

    // back-pressure: hold the output while the input keeps offering words
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    set_geometry(8, 5);
    sink_hold = HoldCycles;
    feed(80, FILL_UNIFORM);
    drain_results();

    // random frames, with now and then a geometry change partway through a frame
    while (pixels_sent < TotalPixels) begin
      src_idle_on  = $urandom_range(0, 2) != 0;
      sink_idle_on = $urandom_range(0, 2) != 0;
      fill = fill_t'($urandom_range(0, 3));
      w = pick_width();
      h = pick_height(w);
      set_geometry(w, h);
      if ($urandom_range(0, 4) == 0) begin
        k = $urandom_range(1, sb.eff_width() * sb.eff_height() - 1);
        feed(k, fill);
        drain_results();
        // only narrow the row so every line-buffer entry read was written
        set_geometry($urandom_range(0, sb.eff_width()), $urandom_range(0, 10));
        rest = sb.frame_rest();
        feed(rest, fill);
        drain_results();
      end else begin
        k = $urandom_range(1, 2) * sb.eff_width() * sb.eff_height();
        feed(k, fill);
        drain_results();
      end
      if (!wide_done && pixels_sent >= TotalPixels / 2) begin
        wide_phase();
        wide_done = 1'b1;
      end
    end

    drain_results();
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
